>>> hw/rtl/lif_pkg.sv
// Shared types, constants and fixed-point helpers for the adaptive LIF neuron update.
// Used by every RTL file of the block but the two interfaces; depends on nothing.
package lif_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned NST = 13;  // pipeline stages, stage 0 is the input register
  localparam int unsigned NEURON_COUNT_DEF = 1024;
  localparam int unsigned PADDR_W = 5;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [33:0] sum_t;
  typedef logic signed [32:0] lim_t;

  localparam word_t E_REST   = -32'sd1174405;
  localparam word_t E_REV    = -32'sd1342177;
  localparam word_t V_FIRE   = -32'sd838861;
  localparam word_t DTHR     = 32'sd1677722;
  localparam word_t G_MAX    = 32'sd2147483647;
  localparam logic [24:0] Q_ONE = 25'd16777216;

  typedef enum logic [2:0] {
    REG_DECAY_AMPA = 3'd0,
    REG_DECAY_GABA = 3'd1,
    REG_DECAY_THR  = 3'd2,
    REG_DECAY_ADPT = 3'd3,
    REG_NMDA_RATE  = 3'd4,
    REG_MEM_RATE   = 3'd5,
    REG_AMPA_FRAC  = 3'd6,
    REG_ADPT_INC   = 3'd7
  } lif_reg_e;

  typedef struct packed {
    logic [23:0] decay_ampa;
    logic [23:0] decay_gaba;
    logic [23:0] decay_threshold;
    logic [23:0] decay_adapt;
    logic [23:0] nmda_rate;
    logic [23:0] mem_rate;
    logic [24:0] ampa_fraction;
    logic [30:0] adapt_increment;
  } lif_cfg_t;

  // per-neuron state word
  typedef struct packed {
    word_t mem;
    word_t thr;
    word_t ampa;
    word_t gaba;
    word_t nmda;
    word_t adapt;
  } state_t;

  localparam state_t STATE_RESET = '{
    mem: E_REST, thr: '0, ampa: '0, gaba: '0, nmda: '0, adapt: '0};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    state_t           data;
  } lif_wr_t;

  // one item in flight
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             live;
    logic [30:0]      exc;
    logic [30:0]      inh;
    word_t            mem;
    word_t            thr;
    word_t            ampa;
    word_t            gaba;
    word_t            nmda;
    word_t            adapt;
    word_t            ginh;
    word_t            gexc;
    word_t            leak;
    word_t            tinh;
    lim_t             thr_lim;
    sum_t             sum;
    wide_t            pa;
    wide_t            pb;
    wide_t            pc;
    logic             spiked;
  } item_t;

  // floor of p / 2^24
  function automatic wide_t q_shift(wide_t p);
    return p >>> 24;
  endfunction

  function automatic word_t sat_g(wide_t v);
    word_t r;
    if (v > wide_t'(G_MAX)) r = G_MAX;
    else if (v < 0) r = '0;
    else r = v[31:0];
    return r;
  endfunction

  function automatic word_t sat_s32(wide_t v);
    word_t r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/lif_in_if.sv
// Input channel of the neuron update: valid/ready with neuron index and increments.
// Depends on nothing.
interface lif_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  neuron;
  logic [30:0] exc_increment;
  logic [30:0] inh_increment;

  modport source(output valid, output neuron, output exc_increment, output inh_increment,
                 input ready);
  modport sink(input valid, input neuron, input exc_increment, input inh_increment,
               output ready);
endinterface

>>> hw/rtl/lif_out_if.sv
// Result channel of the neuron update: valid/ready with index, spike flag, membrane.
// Depends on nothing.
interface lif_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        neuron_out;
  logic              spiked;
  logic signed [31:0] membrane;

  modport source(output valid, output neuron_out, output spiked, output membrane,
                 input ready);
  modport sink(input valid, input neuron_out, input spiked, input membrane,
               output ready);
endinterface

>>> hw/rtl/lif_mem.sv
// Per-neuron state memory with a clearing sweep after reset.
// Depends on lif_pkg.
module lif_mem #(
  parameter int unsigned Depth = lif_pkg::NEURON_COUNT_DEF,
  parameter int unsigned AddrW = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output lif_pkg::state_t       rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  lif_pkg::state_t       wr_data_i,
  output logic                  init_done_o
);

  lif_pkg::state_t  mem_q [Depth];
  lif_pkg::state_t  rd_q;
  logic [AddrW-1:0] clr_q;
  logic             done_q;

  logic             we;
  logic [AddrW-1:0] wa;
  lif_pkg::state_t  wd;

  always_comb begin
    if (!done_q) begin
      we = 1'b1;
      wa = clr_q;
      wd = lif_pkg::STATE_RESET;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      done_q <= 1'b0;
    end else if (!done_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AddrW'(Depth - 1)) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o   = rd_q;
  assign init_done_o = done_q;

endmodule

>>> hw/rtl/lif_pipe.sv
// Thirteen-stage arithmetic pipeline of the neuron update, with hazard probe.
// Depends on lif_pkg; state words come from and go back to lif_mem.
module lif_pipe #(
  parameter int unsigned NeuronCount = lif_pkg::NEURON_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lif_pkg::lif_cfg_t          cfg_i,
  input  logic                       in_vld_i,
  input  logic [lif_pkg::IDX_W-1:0]  in_idx_i,
  input  logic [30:0]                in_exc_i,
  input  logic [30:0]                in_inh_i,
  output logic                       take_o,
  output logic                       hit_o,
  input  lif_pkg::state_t            rd_data_i,
  output lif_pkg::lif_wr_t           wr_o,
  output logic                       out_vld_o,
  input  logic                       out_rdy_i,
  output logic [lif_pkg::IDX_W-1:0]  out_idx_o,
  output logic                       out_spiked_o,
  output lif_pkg::word_t             out_mem_o
);

  localparam int unsigned Last = lif_pkg::NST - 1;

  lif_pkg::item_t s_q [lif_pkg::NST];
  lif_pkg::item_t s_d [lif_pkg::NST];
  logic [lif_pkg::NST-1:0] v_q;
  logic [lif_pkg::NST-1:0] en;

  logic [24:0] af_eff;
  logic [24:0] af_rest;

  assign af_eff  = (cfg_i.ampa_fraction > lif_pkg::Q_ONE) ? lif_pkg::Q_ONE : cfg_i.ampa_fraction;
  assign af_rest = lif_pkg::Q_ONE - af_eff;

  // a stage moves on when it is empty or its successor moves on
  always_comb begin
    en[Last] = !v_q[Last] || out_rdy_i;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // same neuron still in flight (last stage has already written back)
  always_comb begin
    hit_o = 1'b0;
    for (int k = 0; k < Last; k++) begin
      if (v_q[k] && s_q[k].idx == in_idx_i) hit_o = 1'b1;
    end
  end

  always_comb begin
    lif_pkg::wide_t vw;
    lif_pkg::word_t vs;
    logic           spk;

    s_d[0]      = '0;
    s_d[0].idx  = in_idx_i;
    s_d[0].live = 32'(in_idx_i) < 32'(NeuronCount);
    s_d[0].exc  = in_exc_i;
    s_d[0].inh  = in_inh_i;

    // increments on, load state
    s_d[1]       = s_q[0];
    s_d[1].mem   = rd_data_i.mem;
    s_d[1].thr   = rd_data_i.thr;
    s_d[1].nmda  = rd_data_i.nmda;
    s_d[1].adapt = rd_data_i.adapt;
    s_d[1].ampa  = lif_pkg::sat_g(lif_pkg::wide_t'(rd_data_i.ampa) +
                                  lif_pkg::wide_t'(s_q[0].exc));
    s_d[1].gaba  = lif_pkg::sat_g(lif_pkg::wide_t'(rd_data_i.gaba) +
                                  lif_pkg::wide_t'(s_q[0].inh));

    // decays
    s_d[2]       = s_q[1];
    s_d[2].ampa  = lif_pkg::sat_s32(lif_pkg::q_shift(lif_pkg::wide_t'(s_q[1].ampa) *
                                    lif_pkg::wide_t'(cfg_i.decay_ampa)));
    s_d[2].gaba  = lif_pkg::sat_s32(lif_pkg::q_shift(lif_pkg::wide_t'(s_q[1].gaba) *
                                    lif_pkg::wide_t'(cfg_i.decay_gaba)));
    s_d[2].adapt = lif_pkg::sat_s32(lif_pkg::q_shift(lif_pkg::wide_t'(s_q[1].adapt) *
                                    lif_pkg::wide_t'(cfg_i.decay_adapt)));
    s_d[2].thr   = lif_pkg::sat_s32(lif_pkg::q_shift(lif_pkg::wide_t'(s_q[1].thr) *
                                    lif_pkg::wide_t'(cfg_i.decay_threshold)));

    // NMDA rise product, AMPA share product, inhibitory conductance, leak, firing limit
    s_d[3]         = s_q[2];
    s_d[3].pa      = lif_pkg::wide_t'(cfg_i.nmda_rate) * lif_pkg::wide_t'(s_q[2].ampa);
    s_d[3].pb      = lif_pkg::wide_t'(af_eff) * lif_pkg::wide_t'(s_q[2].ampa);
    s_d[3].ginh    = lif_pkg::sat_g(lif_pkg::wide_t'(s_q[2].gaba) +
                                    lif_pkg::wide_t'(s_q[2].adapt));
    s_d[3].leak    = lif_pkg::sat_s32(lif_pkg::wide_t'(s_q[2].mem) -
                                      lif_pkg::wide_t'(lif_pkg::E_REST));
    s_d[3].thr_lim = 33'(lif_pkg::wide_t'(lif_pkg::V_FIRE) + lif_pkg::wide_t'(s_q[2].thr));

    s_d[4]      = s_q[3];
    s_d[4].nmda = lif_pkg::sat_g(lif_pkg::wide_t'(s_q[3].nmda) + lif_pkg::q_shift(s_q[3].pa));
    s_d[4].pc   = lif_pkg::wide_t'(s_q[3].ginh) *
                  (lif_pkg::wide_t'(s_q[3].mem) - lif_pkg::wide_t'(lif_pkg::E_REV));

    s_d[5]      = s_q[4];
    s_d[5].pa   = lif_pkg::wide_t'(cfg_i.nmda_rate) * lif_pkg::wide_t'(s_q[4].nmda);
    s_d[5].tinh = lif_pkg::sat_s32(lif_pkg::q_shift(s_q[4].pc));

    // NMDA leak from the updated value
    s_d[6]      = s_q[5];
    s_d[6].nmda = lif_pkg::sat_g(lif_pkg::wide_t'(s_q[5].nmda) - lif_pkg::q_shift(s_q[5].pa));

    s_d[7]    = s_q[6];
    s_d[7].pa = lif_pkg::wide_t'(af_rest) * lif_pkg::wide_t'(s_q[6].nmda);

    s_d[8]      = s_q[7];
    s_d[8].gexc = lif_pkg::sat_g(lif_pkg::q_shift(s_q[7].pb + s_q[7].pa));

    s_d[9]    = s_q[8];
    s_d[9].pc = lif_pkg::wide_t'(s_q[8].gexc) * (64'sd0 - lif_pkg::wide_t'(s_q[8].mem));

    s_d[10]     = s_q[9];
    s_d[10].sum = 34'(lif_pkg::wide_t'(lif_pkg::sat_s32(lif_pkg::q_shift(s_q[9].pc))) -
                      lif_pkg::wide_t'(s_q[9].tinh) - lif_pkg::wide_t'(s_q[9].leak));

    s_d[11]    = s_q[10];
    s_d[11].pa = lif_pkg::wide_t'(cfg_i.mem_rate) * lif_pkg::wide_t'(s_q[10].sum);

    // Euler step, clip, threshold test, spike reset, zero result for an out-of-range neuron
    s_d[Last] = s_q[Last-1];
    vw  = lif_pkg::wide_t'(s_q[Last-1].mem) + lif_pkg::q_shift(s_q[Last-1].pa);
    vs  = lif_pkg::sat_s32(vw);
    if (vs < lif_pkg::E_REV) vs = lif_pkg::E_REV;
    spk = lif_pkg::wide_t'(vs) > lif_pkg::wide_t'(s_q[Last-1].thr_lim);
    if (!s_q[Last-1].live) begin
      s_d[Last].mem    = '0;
      s_d[Last].spiked = 1'b0;
    end else if (spk) begin
      s_d[Last].mem    = lif_pkg::E_REST;
      s_d[Last].thr    = lif_pkg::DTHR;
      s_d[Last].adapt  = lif_pkg::sat_g(lif_pkg::wide_t'(s_q[Last-1].adapt) +
                                        lif_pkg::wide_t'(cfg_i.adapt_increment));
      s_d[Last].spiked = 1'b1;
    end else begin
      s_d[Last].mem    = vs;
      s_d[Last].spiked = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_vld_i;
      for (int k = 1; k < lif_pkg::NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < lif_pkg::NST; k++) begin
      if (en[k]) s_q[k] <= s_d[k];
    end
  end

  always_comb begin
    wr_o            = '0;
    wr_o.en         = en[Last] && v_q[Last-1] && s_d[Last].live;
    wr_o.idx        = s_d[Last].idx;
    wr_o.data.mem   = s_d[Last].mem;
    wr_o.data.thr   = s_d[Last].thr;
    wr_o.data.ampa  = s_d[Last].ampa;
    wr_o.data.gaba  = s_d[Last].gaba;
    wr_o.data.nmda  = s_d[Last].nmda;
    wr_o.data.adapt = s_d[Last].adapt;
  end

  assign take_o       = en[0];
  assign out_vld_o    = v_q[Last];
  assign out_idx_o    = s_q[Last].idx;
  assign out_spiked_o = s_q[Last].spiked;
  assign out_mem_o    = s_q[Last].mem;

endmodule

>>> hw/rtl/adaptive_lif_neuron_update.sv
// Top level of the adaptive conductance-based LIF neuron update.
// Depends on lif_pkg, lif_in_if, lif_out_if, lif_mem and lif_pipe.
//
// Use: each item on in_i advances one neuron (index plus AMPA/GABA increments)
// by one timestep; one result per item leaves on out_o with the index, the
// spike flag and the new membrane voltage, in item order. Per-neuron state
// lives in one on-chip memory word of six Q8.24 values.
// Throughput: one item per cycle while out_o is not held. An item whose neuron
// is still in the first twelve stages waits at the input until that earlier item
// has written back, so back-to-back repeats of one index cannot overlap.
// Reset: control registers return to their reset values at once; the state
// memory is then swept to its reset values, one neuron per cycle,
// over all NEURON_COUNT neurons, with in_i.ready low. The APB registers take
// writes throughout.
// Stall: the last stage is the output register; while out_o is held the
// pipeline keeps filling its empty stages and then holds. Nothing is lost.
// Configuration: APB, registers at 4*i; the user is to write them only while the block is idle (unchecked).
module adaptive_lif_neuron_update #(
  parameter int unsigned NEURON_COUNT = lif_pkg::NEURON_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lif_in_if.sink                       in_i,
  lif_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lif_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned AddrW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

  lif_pkg::lif_cfg_t cfg_q;
  lif_pkg::lif_reg_e reg_sel;
  lif_pkg::state_t   rd_data;
  lif_pkg::lif_wr_t  wr;
  logic              init_done;
  logic              take;
  logic              hit;
  logic              acc_ok;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign reg_sel = lif_pkg::lif_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_ampa      <= 24'd16445010;
      cfg_q.decay_gaba      <= 24'd16610283;
      cfg_q.decay_threshold <= 24'd15958974;
      cfg_q.decay_adapt     <= 24'd16760447;
      cfg_q.nmda_rate       <= 24'd16777;
      cfg_q.mem_rate        <= 24'd83886;
      cfg_q.ampa_fraction   <= 25'd8388608;
      cfg_q.adapt_increment <= 31'd1677722;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        lif_pkg::REG_DECAY_AMPA: cfg_q.decay_ampa      <= pwdata[23:0];
        lif_pkg::REG_DECAY_GABA: cfg_q.decay_gaba      <= pwdata[23:0];
        lif_pkg::REG_DECAY_THR:  cfg_q.decay_threshold <= pwdata[23:0];
        lif_pkg::REG_DECAY_ADPT: cfg_q.decay_adapt     <= pwdata[23:0];
        lif_pkg::REG_NMDA_RATE:  cfg_q.nmda_rate       <= pwdata[23:0];
        lif_pkg::REG_MEM_RATE:   cfg_q.mem_rate        <= pwdata[23:0];
        lif_pkg::REG_AMPA_FRAC:  cfg_q.ampa_fraction   <= pwdata[24:0];
        lif_pkg::REG_ADPT_INC:   cfg_q.adapt_increment <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lif_pkg::REG_DECAY_AMPA: prdata = 32'(cfg_q.decay_ampa);
      lif_pkg::REG_DECAY_GABA: prdata = 32'(cfg_q.decay_gaba);
      lif_pkg::REG_DECAY_THR:  prdata = 32'(cfg_q.decay_threshold);
      lif_pkg::REG_DECAY_ADPT: prdata = 32'(cfg_q.decay_adapt);
      lif_pkg::REG_NMDA_RATE:  prdata = 32'(cfg_q.nmda_rate);
      lif_pkg::REG_MEM_RATE:   prdata = 32'(cfg_q.mem_rate);
      lif_pkg::REG_AMPA_FRAC:  prdata = 32'(cfg_q.ampa_fraction);
      lif_pkg::REG_ADPT_INC:   prdata = 32'(cfg_q.adapt_increment);
      default:                 prdata = '0;
    endcase
  end

  // ---- input gating: memory swept, no same-neuron item in flight ----
  assign acc_ok     = init_done && !hit;
  assign in_i.ready = take && acc_ok;

  lif_mem #(
    .Depth (NEURON_COUNT),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (take),
    .rd_addr_i   (AddrW'(in_i.neuron)),
    .rd_data_o   (rd_data),
    .wr_en_i     (wr.en),
    .wr_addr_i   (AddrW'(wr.idx)),
    .wr_data_i   (wr.data),
    .init_done_o (init_done)
  );

  lif_pipe #(
    .NeuronCount (NEURON_COUNT)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_vld_i     (in_i.valid && acc_ok),
    .in_idx_i     (in_i.neuron),
    .in_exc_i     (in_i.exc_increment),
    .in_inh_i     (in_i.inh_increment),
    .take_o       (take),
    .hit_o        (hit),
    .rd_data_i    (rd_data),
    .wr_o         (wr),
    .out_vld_o    (out_o.valid),
    .out_rdy_i    (out_o.ready),
    .out_idx_o    (out_o.neuron_out),
    .out_spiked_o (out_o.spiked),
    .out_mem_o    (out_o.membrane)
  );

  // ---- assertions ----
  a_no_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> init_done) else $error("write-back during memory sweep");

  a_spike_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.spiked |-> out_o.membrane == lif_pkg::E_REST)
    else $error("spike without membrane reset");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (32'(out_o.neuron_out) >= 32'(NEURON_COUNT))
    |-> !out_o.spiked && out_o.membrane == '0)
    else $error("out-of-range neuron produced state");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (32'(out_o.neuron_out) < 32'(NEURON_COUNT))
    |-> out_o.membrane >= lif_pkg::E_REV)
    else $error("membrane below reversal clip");

endmodule

>>> sim/lif_update_checker.sv
// Checker for the adaptive LIF neuron update: watches both channels and the APB port,
// predicts each result from its own neuron state and compares. Depends on lif_pkg and
// the lif_in_if / lif_out_if interfaces.
module lif_update_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lif_in_if           in_mon,
  lif_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lif_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEURONS = 1024;

  typedef struct packed {
    logic [9:0]         neuron_out;
    logic               spiked;
    logic signed [31:0] membrane;
  } result_t;

  lif_pkg::lif_cfg_t cfg;
  logic signed [31:0] mem_st[NEURONS];
  logic signed [31:0] thr_st[NEURONS];
  logic signed [31:0] ampa_st[NEURONS];
  logic signed [31:0] gaba_st[NEURONS];
  logic signed [31:0] nmda_st[NEURONS];
  logic signed [31:0] adapt_st[NEURONS];
  result_t expected_results[$];
  int fails;
  int pend;

  assign fail_count_o = fails;
  assign pending_o = pend;

  function automatic longint floor_q(longint p);
    return p >>> 24;
  endfunction

  function automatic longint clamp_cond(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one timestep of one neuron; updates the state copy
  function automatic result_t advance_neuron(logic [9:0] idx, logic [30:0] exc,
                                             logic [30:0] inh);
    result_t r;
    longint ampa, gaba, adapt, nmda, thr, mem, af, gexc, ginh, t_exc, t_inh, t_leak, v;
    logic spike;
    ampa  = clamp_cond(longint'(ampa_st[idx]) + longint'(exc));
    gaba  = clamp_cond(longint'(gaba_st[idx]) + longint'(inh));
    adapt = adapt_st[idx];
    nmda  = nmda_st[idx];
    thr   = thr_st[idx];
    mem   = mem_st[idx];
    ampa  = floor_q(ampa * longint'(cfg.decay_ampa));
    gaba  = floor_q(gaba * longint'(cfg.decay_gaba));
    adapt = floor_q(adapt * longint'(cfg.decay_adapt));
    // NMDA rise uses decayed AMPA, leak uses the risen NMDA
    nmda  = clamp_cond(nmda + floor_q(longint'(cfg.nmda_rate) * ampa));
    nmda  = clamp_cond(nmda - floor_q(longint'(cfg.nmda_rate) * nmda));
    af = longint'(cfg.ampa_fraction);
    if (af > 64'sd16777216) af = 64'sd16777216;
    gexc   = clamp_cond(floor_q(af * ampa + (64'sd16777216 - af) * nmda));
    ginh   = clamp_cond(gaba + adapt);
    t_exc  = clamp_word(floor_q(gexc * (0 - mem)));
    t_inh  = clamp_word(floor_q(ginh * (mem - longint'(lif_pkg::E_REV))));
    t_leak = clamp_word(mem - longint'(lif_pkg::E_REST));
    thr = floor_q(thr * longint'(cfg.decay_threshold));
    v = clamp_word(mem + floor_q(longint'(cfg.mem_rate) * (t_exc - t_inh - t_leak)));
    if (v < longint'(lif_pkg::E_REV)) v = lif_pkg::E_REV;
    spike = v > longint'(lif_pkg::V_FIRE) + thr;
    if (spike) begin
      v = lif_pkg::E_REST;
      thr = lif_pkg::DTHR;
      adapt = clamp_cond(adapt + longint'(cfg.adapt_increment));
    end
    ampa_st[idx]  = ampa[31:0];
    gaba_st[idx]  = gaba[31:0];
    adapt_st[idx] = adapt[31:0];
    nmda_st[idx]  = nmda[31:0];
    thr_st[idx]   = thr[31:0];
    mem_st[idx]   = v[31:0];
    r.neuron_out = idx;
    r.spiked = spike;
    r.membrane = v[31:0];
    return r;
  endfunction

  initial begin
    fails = 0;
    pend = 0;
    cfg = '{decay_ampa: 24'd16445010, decay_gaba: 24'd16610283,
            decay_threshold: 24'd15958974, decay_adapt: 24'd16760447,
            nmda_rate: 24'd16777, mem_rate: 24'd83886,
            ampa_fraction: 25'd8388608, adapt_increment: 31'd1677722};
    for (int i = 0; i < NEURONS; i++) begin
      mem_st[i] = lif_pkg::E_REST;
      thr_st[i] = '0;
      ampa_st[i] = '0;
      gaba_st[i] = '0;
      nmda_st[i] = '0;
      adapt_st[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (lif_pkg::lif_reg_e'(paddr[4:2]))
          lif_pkg::REG_DECAY_AMPA: cfg.decay_ampa      <= pwdata[23:0];
          lif_pkg::REG_DECAY_GABA: cfg.decay_gaba      <= pwdata[23:0];
          lif_pkg::REG_DECAY_THR:  cfg.decay_threshold <= pwdata[23:0];
          lif_pkg::REG_DECAY_ADPT: cfg.decay_adapt     <= pwdata[23:0];
          lif_pkg::REG_NMDA_RATE:  cfg.nmda_rate       <= pwdata[23:0];
          lif_pkg::REG_MEM_RATE:   cfg.mem_rate        <= pwdata[23:0];
          lif_pkg::REG_AMPA_FRAC:  cfg.ampa_fraction   <= pwdata[24:0];
          lif_pkg::REG_ADPT_INC:   cfg.adapt_increment <= pwdata[30:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result for neuron %0d with none expected", out_mon.neuron_out);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.neuron_out !== want.neuron_out) begin
            $error("neuron_out expected %0d actual %0d", want.neuron_out, out_mon.neuron_out);
            fails++;
          end
          if (out_mon.spiked !== want.spiked) begin
            $error("spiked expected %0d actual %0d", want.spiked, out_mon.spiked);
            fails++;
          end
          if (out_mon.membrane !== want.membrane) begin
            $error("membrane expected %0d actual %0d", want.membrane, out_mon.membrane);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(advance_neuron(in_mon.neuron, in_mon.exc_increment,
                                                  in_mon.inh_increment));
      pend = expected_results.size();
    end
  end
endmodule

>>> sim/tb_adaptive_lif_neuron_update.sv
// Testbench top for adaptive_lif_neuron_update: makes stimulus, APB writes and output
// back-pressure, and gives the verdict. Depends on lif_pkg, the channel interfaces,
// the block itself and lif_update_checker.
module tb_adaptive_lif_neuron_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = 30;     // settling slack after the last expected result
  localparam int RANDOM_ITEMS = 400;  // per phase, four phases

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [lif_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending, cycles;
  int idle_pct, stall_pct;

  lif_in_if  in_ch();
  lif_out_if out_ch();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  adaptive_lif_neuron_update dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lif_update_checker checker_inst (
    .clk_i, .rst_ni, .in_mon(in_ch), .out_mon(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver back-pressure, percentage set per phase
  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; register takes it at the access edge
  task automatic apb_write(lif_pkg::lif_reg_e r, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lif_pkg::PADDR_W'({r, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every expected result has arrived, then let the pipe settle
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_all(logic [23:0] da, dg, dt, dd, nr, mr, logic [24:0] af,
                           logic [30:0] ai);
    apb_write(lif_pkg::REG_DECAY_AMPA, 32'(da));
    apb_write(lif_pkg::REG_DECAY_GABA, 32'(dg));
    apb_write(lif_pkg::REG_DECAY_THR, 32'(dt));
    apb_write(lif_pkg::REG_DECAY_ADPT, 32'(dd));
    apb_write(lif_pkg::REG_NMDA_RATE, 32'(nr));
    apb_write(lif_pkg::REG_MEM_RATE, 32'(mr));
    apb_write(lif_pkg::REG_AMPA_FRAC, 32'(af));
    apb_write(lif_pkg::REG_ADPT_INC, 32'(ai));
  endtask

  // one item: optional idle gap, then hold valid until accepted (called at a posedge)
  task automatic send_item(logic [9:0] n, logic [30:0] exc, logic [30:0] inh);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.neuron <= n;
    in_ch.exc_increment <= exc;
    in_ch.inh_increment <= inh;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly a small pool of neurons with drive strong enough to fire; some pure noise
  task automatic random_item();
    logic [9:0] n;
    logic [30:0] exc, inh;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = 10'($urandom);
      exc = 31'($urandom);
      inh = 31'($urandom);
    end else begin
      n = 10'($urandom_range(15));
      if (pick < 20) n = 10'($urandom_range(1023));
      exc = 31'($urandom_range(1 << 24));
      inh = ($urandom_range(3) == 0) ? 31'($urandom_range(1 << 22)) : 31'd0;
    end
    send_item(n, exc, inh);
  endtask

  initial begin
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.neuron = '0;
    in_ch.exc_increment = '0;
    in_ch.inh_increment = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values written explicitly
    write_all(24'd16445010, 24'd16610283, 24'd15958974, 24'd16760447, 24'd16777,
              24'd83886, 25'd8388608, 31'd1677722);

    // directed: field extremes, saturation, a spike train on one neuron
    send_item(10'd0, 31'd0, 31'd0);
    send_item(10'd1023, 31'h7fffffff, 31'h7fffffff);
    send_item(10'd1023, 31'h7fffffff, 31'h7fffffff);  // conductance sum saturates
    send_item(10'd1, 31'h7fffffff, 31'd0);
    send_item(10'd2, 31'd0, 31'h7fffffff);
    send_item(10'h2aa, 31'h2aaaaaaa, 31'h55555555);
    send_item(10'h155, 31'h55555555, 31'h2aaaaaaa);
    for (int k = 0; k < 10; k++) send_item(10'd5, 31'd1 << 26, 31'd0);  // drive to fire
    send_item(10'd1, 31'h7fffffff, 31'd0);
    send_item(10'd2, 31'd0, 31'h7fffffff);
    stop_sending();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      case (phase)
        1: write_all('1, '1, '1, '1, '1, '1, 25'h1ffffff, 31'h7fffffff);  // fraction > 1
        2: write_all('0, '0, '0, '0, '0, '0, 25'd0, 31'd0);
        3: write_all(24'($urandom_range(24'hffffff, 24'hf00000)), 24'($urandom),
                     24'($urandom), 24'($urandom_range(24'hffffff, 24'hf80000)),
                     24'($urandom_range(100000)), 24'($urandom_range(500000)),
                     25'($urandom_range(25'h1000000)), 31'($urandom));
        default: ;
      endcase
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        random_item();
        if (k == RANDOM_ITEMS / 2) begin
          in_ch.valid <= 1'b0;  // hold off until the pipe has emptied
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      stop_sending();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/lif_pkg.sv
hw/rtl/lif_in_if.sv
hw/rtl/lif_out_if.sv
hw/rtl/lif_mem.sv
hw/rtl/lif_pipe.sv
hw/rtl/adaptive_lif_neuron_update.sv
sim/lif_update_checker.sv
sim/tb_adaptive_lif_neuron_update.sv
